// ===== design/mscr_pkg.sv =====
// Shared types, coefficient tables and helpers for the magnetometer calibration pipeline.
package mscr_pkg;

  // Payload of one raw sample transfer
  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } in_t;

  // Payload of one calibrated field transfer
  typedef struct packed {
    logic signed [23:0] field_x;
    logic signed [23:0] field_y;
    logic signed [23:0] field_z;
  } out_t;

  // Configuration port geometry and register indexes
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgGainSelect       = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCorrectionEnable = 2'd1;

  // Datapath widths
  localparam int SW  = 32;  // scaled sample, Q16 microtesla
  localparam int TW  = 33;  // sample plus hard-iron offset
  localparam int PW  = 51;  // soft-iron partial product, Q32
  localparam int AW  = 53;  // soft-iron row sum with rounding term
  localparam int CW  = 32;  // corrected value, Q16
  localparam int DW  = 33;  // x-y and x+y sums
  localparam int RW  = 50;  // rotated value, Q32
  localparam int FW  = 51;  // widened value for final rounding
  localparam int OW  = 24;  // output field width

  // Rotation factor 0.7071 in Q16
  localparam logic [15:0] RotQ16 = 16'd46341;

  // Hard-iron offsets, Q16
  localparam logic signed [20:0] HardQ16 [3] = '{
    21'sd428546, -21'sd993657, -21'sd255178
  };

  // Symmetric soft-iron matrix, Q16
  localparam logic signed [17:0] SoftQ16 [3][3] = '{
    '{ 18'sd68660,  -18'sd468,   18'sd1248 },
    '{ -18'sd468,   18'sd64566, -18'sd4094 },
    '{ 18'sd1248,  -18'sd4094,   18'sd61836 }
  };

  // Gain times 0.1 in Q16: microtesla per raw count
  function automatic logic [14:0] scale_q16(input logic [2:0] sel);
    logic [14:0] s;
    case (sel)
      3'd0:    s = 15'd4784;
      3'd1:    s = 15'd6029;
      3'd2:    s = 15'd7995;
      3'd3:    s = 15'd9961;
      3'd4:    s = 15'd14877;
      3'd5:    s = 15'd16777;
      3'd6:    s = 15'd19857;
      3'd7:    s = 15'd28508;
      default: s = 15'd6029;
    endcase
    return s;
  endfunction

  // Clamp a widened value to the signed output range
  function automatic logic signed [OW-1:0] sat_out(input logic signed [FW-1:0] v);
    logic signed [OW-1:0] r;
    if (v > FW'(signed'(24'sh7FFFFF))) begin
      r = 24'sh7FFFFF;
    end else if (v < FW'(signed'(24'sh800000))) begin
      r = 24'sh800000;
    end else begin
      r = OW'(v);
    end
    return r;
  endfunction

endpackage

// ===== design/magnetometer_scale_calibrate_rotate.sv =====
// Magnetometer scaling, hard/soft-iron correction and 45-degree x/y rotation pipeline.
//
// Usage: raw x/y/z counts arrive on the input channel (in_valid_i, in_stall_o,
// in_data_i); calibrated fields leave on the output channel (out_valid_o,
// out_stall_i, out_data_o) in units of 1/256 microtesla, saturated to 24 bits.
// A transfer happens on a clock edge with valid high and stall low.
// Registers are written through cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i: index 0 is the gain select, index 1 the correction enable.
// cfg_ready_o is always high; write only while the pipeline is empty.
// The pipeline has five register stages (scale multiply, soft-iron products,
// row sum, rotation multiply, round and saturate) and accepts one sample per
// cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its result and each
// stage keeps its data until the next stage frees up; empty stages still
// fill, so in_stall_o only rises once all five stages hold a sample.
// Reset clears all stage valid bits, sets gain select to 1 and turns
// correction off.
module magnetometer_scale_calibrate_rotate
  import mscr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int NumStg = 5;

  // Configuration registers
  logic [2:0] gain_q;
  logic       corr_q;

  // Stage control
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] adv;
  logic [NumStg-1:0] up_vld;

  // Stage payloads
  logic signed [SW-1:0] s_q   [3];
  logic signed [SW-1:0] s_d   [3];
  logic signed [PW-1:0] p_q   [3][3];
  logic signed [PW-1:0] p_d   [3][3];
  logic signed [SW-1:0] sb_q  [3];
  logic signed [CW-1:0] c_q   [3];
  logic signed [CW-1:0] c_d   [3];
  logic signed [RW-1:0] rx_q, ry_q, rx_d, ry_d;
  logic signed [CW-1:0] rz_q;
  out_t                 out_q, out_d;

  logic signed [15:0] raw [3];

  // Accept register writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 3'd1;
      corr_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGainSelect:       gain_q <= cfg_data_i[2:0];
        CfgCorrectionEnable: corr_q <= cfg_data_i[0];
        default:             ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances
  assign up_vld = {vld_q[NumStg-2:0], in_valid_i};
  assign adv[NumStg-1] = !vld_q[NumStg-1] || !out_stall_i;
  for (genvar k = 0; k < NumStg - 1; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NumStg-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (adv[k]) begin
          vld_q[k] <= up_vld[k];
        end
      end
    end
  end

  // Stage 1: scale raw counts to Q16 microtesla
  assign raw[0] = in_data_i.raw_x;
  assign raw[1] = in_data_i.raw_y;
  assign raw[2] = in_data_i.raw_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_d[i] = SW'(raw[i]) * SW'($signed({1'b0, scale_q16(gain_q)}));
    end
  end

  // Stage 2: add hard-iron offsets and form soft-iron products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_d[i][j] = PW'(SoftQ16[i][j]) * PW'(TW'(s_q[j]) + TW'(HardQ16[j]));
      end
    end
  end

  // Stage 3: sum each row and round to Q16, or bypass when correction is off
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (corr_q) begin
        c_d[i] = CW'((AW'(p_q[i][0]) + AW'(p_q[i][1]) + AW'(p_q[i][2])
                      + AW'(signed'(17'sd32768))) >>> 16);
      end else begin
        c_d[i] = sb_q[i];
      end
    end
  end

  // Stage 4: rotate x/y by 45 degrees
  always_comb begin
    rx_d = RW'(DW'(c_q[0]) - DW'(c_q[1])) * RW'($signed({1'b0, RotQ16}));
    ry_d = RW'(DW'(c_q[0]) + DW'(c_q[1])) * RW'($signed({1'b0, RotQ16}));
  end

  // Stage 5: round to 1/256 microtesla and saturate
  always_comb begin
    out_d.field_x = sat_out((FW'(rx_q) + FW'(signed'(25'sh0800000))) >>> 24);
    out_d.field_y = sat_out((FW'(ry_q) + FW'(signed'(25'sh0800000))) >>> 24);
    out_d.field_z = sat_out((FW'(rz_q) + FW'(signed'(9'sd128))) >>> 8);
  end

  // Payload registers, loaded when their stage advances
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s_q <= s_d;
    end
    if (adv[1]) begin
      p_q  <= p_d;
      sb_q <= s_q;
    end
    if (adv[2]) begin
      c_q <= c_d;
    end
    if (adv[3]) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      rz_q <= c_q[2];
    end
    if (adv[4]) begin
      out_q <= out_d;
    end
  end

  // Input is held back only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with an empty stage");

  // An accepted sample lands in stage 1
  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted sample lost at stage 1");

  // A sample behind a stalled output stays in place
  a_hold_stage4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStg-1] && out_stall_i && vld_q[NumStg-2]) |=> vld_q[NumStg-2])
    else $error("stage 4 sample dropped during output stall");

  // A taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !vld_q[NumStg-2]) |=> !out_valid_o)
    else $error("result repeated after transfer");

endmodule
